/* hdl/box3x3_mean_threshold_marker_core_assert.svh */
// Assertion helpers used by the top RTL file of the 3x3 mean threshold core.
`ifndef BOX3X3_MEAN_THRESHOLD_MARKER_CORE_ASSERT_SVH
`define BOX3X3_MEAN_THRESHOLD_MARKER_CORE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define BMTM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define BMTM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* hdl/bmtm_pkg.sv */
`default_nettype none

package bmtm_pkg;

  typedef logic [7:0]  pix_t;
  typedef logic [9:0]  colsum_t;
  typedef logic [11:0] sum_t;
  typedef logic [5:0]  cell_row_t;
  typedef logic [6:0]  cell_col_t;
  typedef logic [7:0]  cfg_data_t;
  typedef logic [1:0]  cfg_idx_t;

  localparam int COLS_W = 8;
  localparam int ROWS_W = 7;

  // Configuration register indexes.
  localparam cfg_idx_t REG_THRESHOLD = 2'd0;
  localparam cfg_idx_t REG_COLS      = 2'd1;
  localparam cfg_idx_t REG_ROWS      = 2'd2;

  localparam int THRESHOLD_RST = 10;
  localparam int COLS_RST      = 80;
  localparam int ROWS_RST      = 20;
  localparam int MIN_DIM       = 3;
  localparam int DIVISOR       = 9;

  // Per-item tag computed at acceptance and carried with the pixel.
  typedef struct packed {
    logic      emit;
    logic      last;
    cell_row_t cell_row;
    cell_col_t cell_col;
  } tag_t;

  typedef struct packed {
    logic      is_star;
    cell_row_t cell_row;
    cell_col_t cell_col;
    sum_t      window_sum;
    logic      last;
  } res_t;

endpackage

`default_nettype wire

/* hdl/bmtm_if.sv */
`default_nettype none

interface bmtm_pixel_if;
  logic            valid;
  logic            ready;
  bmtm_pkg::pix_t  pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface bmtm_result_if;
  logic                 valid;
  logic                 ready;
  logic                 is_star;
  bmtm_pkg::cell_row_t  cell_row;
  bmtm_pkg::cell_col_t  cell_col;
  bmtm_pkg::sum_t       window_sum;
  logic                 last;

  modport source (output valid, output is_star, output cell_row, output cell_col,
                  output window_sum, output last, input ready);
  modport sink   (input valid, input is_star, input cell_row, input cell_col,
                  input window_sum, input last, output ready);
endinterface

`default_nettype wire

/* hdl/bmtm_ram.sv */
`default_nettype none

module bmtm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* hdl/bmtm_scan.sv */
`default_nettype none

module bmtm_scan #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire bmtm_pkg::cfg_idx_t          cfg_idx_i,
  input  wire bmtm_pkg::cfg_data_t         cfg_data_i,
  input  wire logic                        advance_i,
  output logic [$clog2(MAX_COLS)-1:0]      col_o,
  output bmtm_pkg::tag_t                   tag_o,
  output bmtm_pkg::sum_t                   limit_o
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int ColsRstCl = (bmtm_pkg::COLS_RST > MAX_COLS) ? MAX_COLS : bmtm_pkg::COLS_RST;
  localparam int RowsRstCl = (bmtm_pkg::ROWS_RST > MAX_ROWS) ? MAX_ROWS : bmtm_pkg::ROWS_RST;
  localparam logic [CW-1:0] ColLastRst = CW'(ColsRstCl - 1);
  localparam logic [RW-1:0] RowLastRst = RW'(RowsRstCl - 1);
  localparam bmtm_pkg::sum_t LimitRst =
    bmtm_pkg::sum_t'(bmtm_pkg::THRESHOLD_RST * bmtm_pkg::DIVISOR + bmtm_pkg::DIVISOR - 1);

  logic [CW-1:0]  col_q, col_d, col_last_q, col_last_d;
  logic [RW-1:0]  row_q, row_d, row_last_q, row_last_d;
  bmtm_pkg::sum_t limit_q, limit_d;
  logic           geom_wr;
  int unsigned    cols_req, rows_req;

  // Clamp requested geometry and keep the last index of each dimension.
  always_comb begin
    cols_req = 32'(cfg_data_i[bmtm_pkg::COLS_W-1:0]);
    rows_req = 32'(cfg_data_i[bmtm_pkg::ROWS_W-1:0]);
    if (cols_req < bmtm_pkg::MIN_DIM) cols_req = bmtm_pkg::MIN_DIM;
    if (cols_req > MAX_COLS)          cols_req = MAX_COLS;
    if (rows_req < bmtm_pkg::MIN_DIM) rows_req = bmtm_pkg::MIN_DIM;
    if (rows_req > MAX_ROWS)          rows_req = MAX_ROWS;
  end

  always_comb begin
    col_last_d = col_last_q;
    row_last_d = row_last_q;
    limit_d    = limit_q;
    geom_wr    = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        bmtm_pkg::REG_THRESHOLD: begin
          // mean > thr  <=>  sum > 9*thr + 8
          limit_d = bmtm_pkg::sum_t'(bmtm_pkg::sum_t'(cfg_data_i) *
                                     bmtm_pkg::sum_t'(bmtm_pkg::DIVISOR)) +
                    bmtm_pkg::sum_t'(bmtm_pkg::DIVISOR - 1);
        end
        bmtm_pkg::REG_COLS: begin
          col_last_d = CW'(cols_req - 32'd1);
          geom_wr    = 1'b1;
        end
        bmtm_pkg::REG_ROWS: begin
          row_last_d = RW'(rows_req - 32'd1);
          geom_wr    = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (geom_wr) begin
      col_d = '0;
      row_d = '0;
    end else if (advance_i) begin
      if (col_q == col_last_q) begin
        col_d = '0;
        row_d = (row_q == row_last_q) ? '0 : RW'(row_q + 1'b1);
      end else begin
        col_d = CW'(col_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      col_last_q <= ColLastRst;
      row_last_q <= RowLastRst;
      limit_q    <= LimitRst;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      col_last_q <= col_last_d;
      row_last_q <= row_last_d;
      limit_q    <= limit_d;
    end
  end

  always_comb begin
    tag_o.emit     = (32'(row_q) >= 32'd2) && (32'(col_q) >= 32'd2);
    tag_o.last     = (row_q == row_last_q) && (col_q == col_last_q);
    tag_o.cell_row = bmtm_pkg::cell_row_t'(32'(row_q) - 32'd1);
    tag_o.cell_col = bmtm_pkg::cell_col_t'(32'(col_q) - 32'd1);
  end

  assign col_o   = col_q;
  assign limit_o = limit_q;

endmodule

`default_nettype wire

/* hdl/bmtm_window.sv */
`default_nettype none

module bmtm_window (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            fire_i,
  input  wire bmtm_pkg::pix_t  px_i,
  input  wire bmtm_pkg::pix_t  up1_i,
  input  wire bmtm_pkg::pix_t  up2_i,
  input  wire bmtm_pkg::tag_t  tag_i,
  input  wire bmtm_pkg::sum_t  limit_i,
  input  wire logic            out_ready_i,
  output logic                 take_ok_o,
  output logic                 out_valid_o,
  output bmtm_pkg::res_t       res_o
);

  // Two previous columns kept as column sums.
  bmtm_pkg::colsum_t cs_old_q, cs_new_q, col_sum;
  bmtm_pkg::sum_t    win_sum;
  logic              out_valid_q, out_valid_d;
  bmtm_pkg::res_t    res_q, res_d;

  always_comb begin
    col_sum = bmtm_pkg::colsum_t'(up2_i) + bmtm_pkg::colsum_t'(up1_i) +
              bmtm_pkg::colsum_t'(px_i);
    win_sum = bmtm_pkg::sum_t'(cs_old_q) + bmtm_pkg::sum_t'(cs_new_q) +
              bmtm_pkg::sum_t'(col_sum);
  end

  assign take_ok_o = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (fire_i && tag_i.emit) begin
      out_valid_d      = 1'b1;
      res_d.is_star    = win_sum > limit_i;
      res_d.cell_row   = tag_i.cell_row;
      res_d.cell_col   = tag_i.cell_col;
      res_d.window_sum = win_sum;
      res_d.last       = tag_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_old_q    <= '0;
      cs_new_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire_i) begin
        cs_old_q <= cs_new_q;
        cs_new_q <= col_sum;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

/* hdl/box3x3_mean_threshold_marker_core.sv */
// 3x3 box mean threshold marker.
// Pixels enter on pix_i in row order, one item per valid/ready handshake;
// the raster is cols_in_use wide and rows_in_use tall (clamped to 3..MAX_COLS
// and 3..MAX_ROWS). Each interior cell yields one item on res_o when the pixel
// to its lower right arrives: star flag, cell position, 3x3 sum and a last
// flag on the final interior cell. Border positions yield nothing.
// A result is registered when the pixel that completes it leaves stage 1.
// Throughput: one pixel per cycle while the receiver does not stall, set by
// the single shared line-store RAM (read at acceptance, written from stage 1).
// The receiver may stall: a stalled result waits in the output register and
// the pixel behind it waits in stage 1; pix_i.ready drops in any cycle in
// which both are occupied and res_o.ready is low.
// Configuration writes (cfg_we_i/cfg_idx_i/cfg_data_i) go in while idle; the
// user must keep to this, since the block does not enforce it. Writing either
// geometry register restarts the raster at row 0, column 0. Reset: counters go
// to zero, threshold to 10, geometry to 80x20; the line store is not cleared
// and needs no sweep, as its entries are written before any result reads them.
`default_nettype none
`include "box3x3_mean_threshold_marker_core_assert.svh"

module box3x3_mean_threshold_marker_core #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire bmtm_pkg::cfg_idx_t  cfg_idx_i,
  input  wire bmtm_pkg::cfg_data_t cfg_data_i,
  bmtm_pixel_if.sink               pix_i,
  bmtm_result_if.source            res_o
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int PW = $bits(bmtm_pkg::pix_t);

  logic             accept, s1_fire, take_ok, out_valid;
  logic [CW-1:0]    col;
  bmtm_pkg::tag_t   tag;
  bmtm_pkg::sum_t   limit;
  bmtm_pkg::res_t   res;
  logic [2*PW-1:0]  ram_rdata;

  // Stage 1: the accepted pixel while its line-store read completes.
  logic             s1_valid_q, s1_valid_d;
  bmtm_pkg::pix_t   s1_px_q;
  logic [CW-1:0]    s1_col_q;
  bmtm_pkg::tag_t   s1_tag_q;

  // Advance stage 1 when the output register can take its result.
  assign s1_fire     = s1_valid_q && take_ok;
  assign pix_i.ready = !s1_valid_q || take_ok;
  assign accept      = pix_i.valid && pix_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q  <= pix_i.pixel;
      s1_col_q <= col;
      s1_tag_q <= tag;
    end
  end

  bmtm_scan #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .advance_i  (accept),
    .col_o      (col),
    .tag_o      (tag),
    .limit_o    (limit)
  );

  // Line store: upper byte is two rows up, lower byte one row up. Read the
  // new column at acceptance, write back {one row up, pixel} at stage 1.
  // Consecutive items never share a column, so no forwarding is needed.
  bmtm_ram #(
    .WIDTH (2 * PW),
    .DEPTH (MAX_COLS)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_col_q),
    .wdata_i ({ram_rdata[PW-1:0], s1_px_q}),
    .re_i    (accept),
    .raddr_i (col),
    .rdata_o (ram_rdata)
  );

  bmtm_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (s1_fire),
    .px_i        (s1_px_q),
    .up1_i       (ram_rdata[PW-1:0]),
    .up2_i       (ram_rdata[2*PW-1:PW]),
    .tag_i       (s1_tag_q),
    .limit_i     (limit),
    .out_ready_i (res_o.ready),
    .take_ok_o   (take_ok),
    .out_valid_o (out_valid),
    .res_o       (res)
  );

  assign res_o.valid      = out_valid;
  assign res_o.is_star    = res.is_star;
  assign res_o.cell_row   = res.cell_row;
  assign res_o.cell_col   = res.cell_col;
  assign res_o.window_sum = res.window_sum;
  assign res_o.last       = res.last;

  // Read and write-back must never land on the same line-store entry.
  `BMTM_ASSERT_NEVER(a_ram_same_entry, clk_i, rst_ni,
    accept && s1_fire && (col == s1_col_q), "line store read and write collide")
  // A stalled stage 1 keeps its item and column.
  `BMTM_ASSERT(a_s1_hold, clk_i, rst_ni,
    (s1_valid_q && !s1_fire) |=> (s1_valid_q && $stable(s1_col_q)),
    "stage 1 lost a stalled item")
  // A result never names a border cell.
  `BMTM_ASSERT_NEVER(a_no_border, clk_i, rst_ni,
    out_valid && ((res.cell_row == '0) || (res.cell_col == '0)),
    "result reported for a border cell")

endmodule

`default_nettype wire
